// ----- src/hps_pkg.sv -----
// Shared types and constants for the Hamiltonian path search unit.
package hps_pkg;

    localparam int VTX_W  = 4;
    localparam int ROW_W  = 16;
    localparam int CNT_W  = 5;
    localparam int SLOTS  = 16;
    localparam int SLOT_W = 4;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [VTX_W-1:0] row_index;
        logic [ROW_W-1:0] row_bits;
        logic [VTX_W-1:0] start_vertex;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [VTX_W-1:0] path_vertex;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [VTX_W-1:0] vtx;
        logic [CNT_W-1:0] nxt;
    } t_stk_entry;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        t_stk_entry        wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } t_stk_req;

    // index of the lowest set bit; zero for an empty word
    function automatic logic [VTX_W-1:0] lowest_bit(input logic [ROW_W-1:0] word);
        logic [VTX_W-1:0] idx;
        idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (word[i]) idx = VTX_W'(i);
        end
        return idx;
    endfunction

endpackage

// ----- src/hps_adj_ram.sv -----
// Adjacency row memory: one write port, one registered read port.
module hps_adj_ram
    import hps_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [ROW_W-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [ROW_W-1:0]         o_rdata
);

    logic [ROW_W-1:0] r_mem [DEPTH];
    logic [ROW_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/hps_stack_ram.sv -----
// Search stack memory: path vertex and resume point per level.
module hps_stack_ram
    import hps_pkg::*;
(
    input  logic       i_clk,
    input  t_stk_req   i_req,
    output t_stk_entry o_rdata
);

    t_stk_entry r_mem [SLOTS];
    t_stk_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/hamiltonian_path_search_unit.sv -----
// Hamiltonian path search unit: backtracking depth-first search over a stored graph.
//
// Input channel (i_in_valid / o_in_stall) carries items of two kinds. A load item
// writes one adjacency row and gives no result. A search item runs a backtracking
// search from its start vertex over the first vertex_count vertices (capped at ADJ_DEPTH).
// Output channel (o_out_valid / i_out_stall) returns the path one vertex per item,
// last marked, or a single item with found low when no path exists.
// i_cfg_we / i_cfg_wdata write vertex_count (reset value 16). The user is to write it
// while the unit is idle; the unit does not enforce this. Each search step is an
// adjacency read (S_CHK) then a scan (S_SCAN); a backtrack adds a stack read (S_POP)
// to restore the level below. The step count depends on the graph and is at least one
// per vertex; the worst case is exponential in n. Emission reads each path vertex but
// the last back from the stack memory (S_ORD, then S_OWR); the last comes from the
// current vertex register. New items wait (o_in_stall high) until the last result has
// been placed in the output register.
// A stalled result holds in the output register; the unit waits for it.
// Reset clears control state and the output valid flag and sets vertex_count to 16; memory contents stay.
module hamiltonian_path_search_unit
    import hps_pkg::*;
#(
    parameter int MAX_VERTICES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item
);

    localparam int ADJ_DEPTH = (MAX_VERTICES < SLOTS) ? MAX_VERTICES : SLOTS;
    localparam int ADJ_AW    = $clog2(ADJ_DEPTH);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(ADJ_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_FAIL = 3'd4;
    localparam logic [2:0] S_ORD  = 3'd5;
    localparam logic [2:0] S_OWR  = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_vc;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [VTX_W-1:0]  r_start, n_start;
    logic [ROW_W-1:0]  r_vis, n_vis;
    logic [CNT_W-1:0]  r_depth, n_depth;
    logic [VTX_W-1:0]  r_cur_v, n_cur_v;
    logic [CNT_W-1:0]  r_cur_nx, n_cur_nx;
    logic [SLOT_W-1:0] r_k, n_k;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              in_acc;
    logic              out_free;
    logic [CNT_W-1:0]  cnt_use;
    logic              adj_we;
    logic              adj_re;
    logic [ROW_W-1:0]  adj_rdata;
    t_stk_req          stk_req;
    t_stk_entry        stk_rdata;
    logic [ROW_W-1:0]  cand;
    logic [VTX_W-1:0]  pick;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign cnt_use  = (r_vc > CAP) ? CAP : r_vc;

    assign cand = adj_rdata & ~r_vis & ~(ROW_W'(1) << r_cur_v)
                & ~({ROW_W{1'b1}} << r_n) & ({ROW_W{1'b1}} << r_cur_nx);
    assign pick = lowest_bit(cand);

    assign adj_we = in_acc && (i_in_item.mode == MODE_LOAD)
                 && ({1'b0, i_in_item.row_index} < CAP);
    assign adj_re = (r_state == S_CHK) && (r_depth < r_n);

    hps_adj_ram #(
        .DEPTH (ADJ_DEPTH)
    ) u_adj (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (i_in_item.row_index[ADJ_AW-1:0]),
        .i_wdata (i_in_item.row_bits),
        .i_re    (adj_re),
        .i_raddr (r_cur_v[ADJ_AW-1:0]),
        .o_rdata (adj_rdata)
    );

    hps_stack_ram u_stk (
        .i_clk   (i_clk),
        .i_req   (stk_req),
        .o_rdata (stk_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_start     = r_start;
        n_vis       = r_vis;
        n_depth     = r_depth;
        n_cur_v     = r_cur_v;
        n_cur_nx    = r_cur_nx;
        n_k         = r_k;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        stk_req     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_item.mode == MODE_SEARCH)) begin
                    n_n     = cnt_use;
                    n_start = i_in_item.start_vertex;
                    if ((cnt_use == '0) || ({1'b0, i_in_item.start_vertex} >= cnt_use)) begin
                        n_state = S_FAIL;
                    end else begin
                        n_vis    = ROW_W'(1) << i_in_item.start_vertex;
                        n_cur_v  = i_in_item.start_vertex;
                        n_cur_nx = '0;
                        n_depth  = CNT_W'(1);
                        n_state  = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (r_depth >= r_n) begin
                    n_k     = '0;
                    n_state = S_ORD;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (cand != '0) begin
                    stk_req.we        = 1'b1;
                    stk_req.waddr     = SLOT_W'(r_depth - CNT_W'(1));
                    stk_req.wdata.vtx = r_cur_v;
                    stk_req.wdata.nxt = CNT_W'(pick) + CNT_W'(1);
                    n_vis    = r_vis | (ROW_W'(1) << pick);
                    n_cur_v  = pick;
                    n_cur_nx = '0;
                    n_depth  = r_depth + CNT_W'(1);
                    n_state  = S_CHK;
                end else begin
                    n_vis   = r_vis & ~(ROW_W'(1) << r_cur_v);
                    n_depth = r_depth - CNT_W'(1);
                    if (r_depth == CNT_W'(1)) begin
                        n_state = S_FAIL;
                    end else begin
                        stk_req.re    = 1'b1;
                        stk_req.raddr = SLOT_W'(r_depth - CNT_W'(2));
                        n_state       = S_POP;
                    end
                end
            end
            S_POP: begin
                n_cur_v  = stk_rdata.vtx;
                n_cur_nx = stk_rdata.nxt;
                n_state  = S_CHK;
            end
            S_FAIL: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.found       = 1'b0;
                    n_out.path_vertex = r_start;
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_ORD: begin
                if ({1'b0, r_k} == (r_n - CNT_W'(1))) begin
                    if (out_free) begin
                        n_out_valid       = 1'b1;
                        n_out.found       = 1'b1;
                        n_out.path_vertex = r_cur_v;
                        n_out.last        = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    stk_req.re    = 1'b1;
                    stk_req.raddr = r_k;
                    n_state       = S_OWR;
                end
            end
            S_OWR: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.found       = 1'b1;
                    n_out.path_vertex = stk_rdata.vtx;
                    n_out.last        = 1'b0;
                    n_k               = r_k + SLOT_W'(1);
                    n_state           = S_ORD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vc        <= CNT_W'(16);
            r_out_valid <= 1'b0;
            r_depth     <= '0;
            r_vis       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_depth     <= n_depth;
            r_vis       <= n_vis;
            if (i_cfg_we) begin
                r_vc <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_start  <= n_start;
        r_cur_v  <= n_cur_v;
        r_cur_nx <= n_cur_nx;
        r_k      <= n_k;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- src/hps_checker.sv -----
// Port-level checks for the Hamiltonian path search unit, bound to the top level.
module hps_checker
    import hps_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_item.mode == MODE_SEARCH)) |=> o_in_stall)
        else $error("search item accepted without going busy");

    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.found) |-> o_out_item.last)
        else $error("failed search item not marked last");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind hamiltonian_path_search_unit hps_checker u_hps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
